// ----- rtl/ceri_pkg.sv -----
// Shared types, constants and small functions for the corner/edge state ranker.
package ceri_pkg;

    localparam int unsigned CORNER_POS = 8;
    localparam int unsigned EDGE_POS   = 12;
    localparam int unsigned GROUP_SIZE = 4;

    localparam logic [4:0]  FIELD_MAX       = 5'd23;
    localparam logic [4:0]  EDGE_POS_FIELD  = 5'd12;
    localparam logic [13:0] EDGE_PLACEMENTS = 14'd11880;
    localparam logic [4:0]  GROUP_ORDERS    = 5'd24;

    typedef logic [2:0] t_cpos;
    typedef logic [3:0] t_epos;
    typedef logic [7:0] t_term;

    typedef struct packed {
        logic [4:0] corner_a;
        logic [4:0] corner_b;
        logic [4:0] corner_c;
        logic [4:0] corner_d;
        logic [4:0] edge_a;
        logic [4:0] edge_b;
        logic [4:0] edge_c;
        logic [4:0] edge_d;
    } t_in_word;

    typedef struct packed {
        logic [24:0] placement_rank;
        logic [10:0] twist_flip_rank;
        logic        input_ok;
    } t_out_word;

    typedef struct packed {
        t_cpos [GROUP_SIZE-1:0] cpos;
        t_epos [GROUP_SIZE-1:0] epos;
        logic  [CORNER_POS-1:0] cmask;
        logic  [EDGE_POS-1:0]   emask;
        logic  [10:0]           twist_flip;
        logic                   ok;
    } t_dec_word;

    typedef struct packed {
        t_term [CORNER_POS-1:0] cterm;
        t_term [EDGE_POS-1:0]   eterm;
        logic  [4:0]            clehm;
        logic  [4:0]            elehm;
        logic  [10:0]           twist_flip;
        logic                   ok;
    } t_term_word;

    typedef struct packed {
        logic [10:0] crank;
        logic [13:0] erank;
        logic [10:0] twist_flip;
        logic        ok;
    } t_rank_word;

    // Binomial coefficient n choose k for n up to 11 and k up to 3.
    function automatic t_term choose(input logic [3:0] n, input logic [1:0] k);
        t_term r;
        r = '0;
        unique case (k)
            2'd0: r = 8'd1;
            2'd1: r = {4'd0, n};
            2'd2: begin
                case (n)
                    4'd2:  r = 8'd1;
                    4'd3:  r = 8'd3;
                    4'd4:  r = 8'd6;
                    4'd5:  r = 8'd10;
                    4'd6:  r = 8'd15;
                    4'd7:  r = 8'd21;
                    4'd8:  r = 8'd28;
                    4'd9:  r = 8'd36;
                    4'd10: r = 8'd45;
                    4'd11: r = 8'd55;
                    default: r = 8'd0;
                endcase
            end
            2'd3: begin
                case (n)
                    4'd3:  r = 8'd1;
                    4'd4:  r = 8'd4;
                    4'd5:  r = 8'd10;
                    4'd6:  r = 8'd20;
                    4'd7:  r = 8'd35;
                    4'd8:  r = 8'd56;
                    4'd9:  r = 8'd84;
                    4'd10: r = 8'd120;
                    4'd11: r = 8'd165;
                    default: r = 8'd0;
                endcase
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Lehmer rank of four distinct positions in the order given.
    function automatic logic [4:0] lehmer(input logic [3:0] p0, input logic [3:0] p1,
                                          input logic [3:0] p2, input logic [3:0] p3);
        logic [1:0] d0;
        logic [1:0] d1;
        d0 = 2'(p0 > p1) + 2'(p0 > p2) + 2'(p0 > p3);
        d1 = 2'(p1 > p2) + 2'(p1 > p3);
        return 5'(d0) * 5'd6 + 5'(d1) * 5'd2 + 5'(p2 > p3);
    endfunction

endpackage

// ----- rtl/ceri_decode.sv -----
// Stage one: field decode, range and repeat checks, occupancy masks, twist/flip rank.
module ceri_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ceri_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output ceri_pkg::t_dec_word o_word
);
    import ceri_pkg::*;

    logic      r_valid;
    t_dec_word r_word;
    t_dec_word n_word;

    logic [4:0] cf [GROUP_SIZE];
    logic [4:0] ef [GROUP_SIZE];
    logic [1:0] ct [GROUP_SIZE];
    logic [6:0] twist;
    logic [3:0] flip;
    logic       range_ok;
    logic       dup;

    always_comb begin
        cf[0] = i_word.corner_a;
        cf[1] = i_word.corner_b;
        cf[2] = i_word.corner_c;
        cf[3] = i_word.corner_d;
        ef[0] = i_word.edge_a;
        ef[1] = i_word.edge_b;
        ef[2] = i_word.edge_c;
        ef[3] = i_word.edge_d;
        n_word   = '0;
        range_ok = 1'b1;
        dup      = 1'b0;
        flip     = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            range_ok = range_ok && (cf[i] <= FIELD_MAX) && (ef[i] <= FIELD_MAX);
            n_word.cpos[i] = cf[i][2:0];
            ct[i]          = cf[i][4:3];
            if (ef[i] >= EDGE_POS_FIELD) begin
                n_word.epos[i] = 4'(ef[i] - EDGE_POS_FIELD);
                flip[i]        = 1'b1;
            end else begin
                n_word.epos[i] = ef[i][3:0];
            end
            n_word.cmask[n_word.cpos[i]] = 1'b1;
            n_word.emask[n_word.epos[i]] = 1'b1;
        end
        for (int i = 0; i < GROUP_SIZE; i++) begin
            for (int j = i + 1; j < GROUP_SIZE; j++) begin
                dup = dup || (n_word.cpos[i] == n_word.cpos[j])
                          || (n_word.epos[i] == n_word.epos[j]);
            end
        end
        // Corner twists read as a base-3 number, corner_a least significant.
        twist = 7'(ct[0]) + 7'(ct[1]) * 7'd3 + 7'(ct[2]) * 7'd9 + 7'(ct[3]) * 7'd27;
        n_word.twist_flip = {twist, flip};
        n_word.ok         = range_ok && !dup;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ----- rtl/ceri_terms.sv -----
// Stage two: per-position combination terms and Lehmer ranks of both groups.
module ceri_terms (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ceri_pkg::t_dec_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ceri_pkg::t_term_word o_word
);
    import ceri_pkg::*;

    logic       r_valid;
    t_term_word r_word;
    t_term_word n_word;

    logic [CORNER_POS-1:0] clow;
    logic [EDGE_POS-1:0]   elow;
    logic [2:0]            ccnt;
    logic [2:0]            ecnt;

    always_comb begin
        n_word = '0;
        // Each free position adds C(positions above it, pieces still to place minus one).
        for (int j = 0; j < CORNER_POS; j++) begin
            clow = CORNER_POS'((16'd1 << j) - 16'd1);
            ccnt = 3'($countones(i_word.cmask & clow));
            if (!i_word.cmask[j] && ccnt <= 3'd3) begin
                n_word.cterm[j] = choose(4'(CORNER_POS - 1 - j), 2'(3 - ccnt));
            end
        end
        for (int j = 0; j < EDGE_POS; j++) begin
            elow = EDGE_POS'((16'd1 << j) - 16'd1);
            ecnt = 3'($countones(i_word.emask & elow));
            if (!i_word.emask[j] && ecnt <= 3'd3) begin
                n_word.eterm[j] = choose(4'(EDGE_POS - 1 - j), 2'(3 - ecnt));
            end
        end
        n_word.clehm = lehmer({1'b0, i_word.cpos[0]}, {1'b0, i_word.cpos[1]},
                              {1'b0, i_word.cpos[2]}, {1'b0, i_word.cpos[3]});
        n_word.elehm = lehmer(i_word.epos[0], i_word.epos[1],
                              i_word.epos[2], i_word.epos[3]);
        n_word.twist_flip = i_word.twist_flip;
        n_word.ok         = i_word.ok;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ----- rtl/ceri_rank.sv -----
// Stage three: sums the combination terms and forms each group's placement rank.
module ceri_rank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ceri_pkg::t_term_word i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ceri_pkg::t_rank_word o_word
);
    import ceri_pkg::*;

    logic       r_valid;
    t_rank_word r_word;
    t_rank_word n_word;

    logic [8:0] csum2 [CORNER_POS/2];
    logic [8:0] esum2 [EDGE_POS/2];
    logic [8:0] esum4 [EDGE_POS/4];
    logic [8:0] csum;
    logic [8:0] esum;

    always_comb begin
        for (int i = 0; i < CORNER_POS / 2; i++) begin
            csum2[i] = 9'(i_word.cterm[2*i]) + 9'(i_word.cterm[2*i+1]);
        end
        for (int i = 0; i < EDGE_POS / 2; i++) begin
            esum2[i] = 9'(i_word.eterm[2*i]) + 9'(i_word.eterm[2*i+1]);
        end
        for (int i = 0; i < EDGE_POS / 4; i++) begin
            esum4[i] = esum2[2*i] + esum2[2*i+1];
        end
        csum = (csum2[0] + csum2[1]) + (csum2[2] + csum2[3]);
        esum = esum4[0] + esum4[1] + esum4[2];
        n_word.crank      = 11'(csum) * 11'(GROUP_ORDERS) + 11'(i_word.clehm);
        n_word.erank      = 14'(esum) * 14'(GROUP_ORDERS) + 14'(i_word.elehm);
        n_word.twist_flip = i_word.twist_flip;
        n_word.ok         = i_word.ok;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ----- rtl/ceri_combine.sv -----
// Stage four: scales the corner rank, adds the edge rank and zeroes bad words.
module ceri_combine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ceri_pkg::t_rank_word i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ceri_pkg::t_out_word  o_word
);
    import ceri_pkg::*;

    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;

    always_comb begin
        n_word = '0;
        if (i_word.ok) begin
            n_word.placement_rank  = 25'(i_word.crank) * 25'(EDGE_PLACEMENTS)
                                   + 25'(i_word.erank);
            n_word.twist_flip_rank = i_word.twist_flip;
            n_word.input_ok        = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ----- rtl/corner_edge_state_rank_index.sv -----
// Throughput: one word per cycle while the output side keeps taking words; each of
// the four pipeline registers holds one word.
// Each stage stalls only when it is full and the stage after it cannot take its word.
// Reset (synchronous, active low) clears all stage valid bits; no payload is reset.
// The block keeps no state between words.
module corner_edge_state_rank_index (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ceri_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ceri_pkg::t_out_word o_out_word
);
    import ceri_pkg::*;

    logic       dec_valid;
    logic       dec_ready;
    t_dec_word  dec_word;
    logic       term_valid;
    logic       term_ready;
    t_term_word term_word;
    logic       rank_valid;
    logic       rank_ready;
    t_rank_word rank_word;

    ceri_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_word  (dec_word)
    );

    ceri_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_word  (dec_word),
        .o_valid (term_valid),
        .i_ready (term_ready),
        .o_word  (term_word)
    );

    ceri_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (term_valid),
        .o_ready (term_ready),
        .i_word  (term_word),
        .o_valid (rank_valid),
        .i_ready (rank_ready),
        .o_word  (rank_word)
    );

    ceri_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rank_valid),
        .o_ready (rank_ready),
        .i_word  (rank_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // An empty output register lets every stage move, so the input must be ready.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output register is empty");

    a_bad_word_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.input_ok) |->
            (o_out_word.placement_rank == 25'd0 && o_out_word.twist_flip_rank == 11'd0))
        else $error("rejected word carries nonzero ranks");

    a_group_ranks_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rank_valid && rank_word.ok) |->
            (rank_word.crank < 11'd1680 && rank_word.erank < EDGE_PLACEMENTS))
        else $error("group placement rank out of range");

    a_output_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_word.placement_rank < 25'd19958400 && o_out_word.twist_flip_rank < 11'd1296))
        else $error("result rank out of range");

endmodule

// ----- verif/corner_edge_state_rank_index_tb.sv -----
// Self-checking testbench for the corner/edge state ranker: directed, random and stall tests.
module corner_edge_state_rank_index_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ceri_pkg::*;

    localparam int unsigned EDGE_SPAN      = 11880;
    localparam int unsigned ORDERS_PER_SET = 24;
    localparam int unsigned FLIP_WEIGHT    = 16;
    localparam int unsigned FIELD_TOP      = 23;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLDOFF_CYCLES = 160;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    t_out_word rank_queue[$];
    bit        send_idle_en;
    bit        recv_idle_en;
    bit        holdoff_req;
    int        n_sent;
    int        n_rejected;
    int        n_results;
    int        n_errors;
    int        quiet_cycles;

    corner_edge_state_rank_index u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic int unsigned binomial(input int unsigned n, input int unsigned k);
        int unsigned r;
        r = 1;
        for (int unsigned i = 0; i < k; i++) begin
            r = r * (n - i) / (i + 1);
        end
        return r;
    endfunction

    // Placement rank of four positions out of npos: subset rank times 24 plus order rank.
    function automatic bit place_rank(input int unsigned p [4], input int unsigned npos,
                                      output int unsigned rank);
        bit [11:0]   occupied;
        int unsigned found;
        int unsigned subset;
        occupied = '0;
        found    = 0;
        subset   = 0;
        rank     = 0;
        for (int i = 0; i < 4; i++) begin
            if (occupied[p[i]]) begin
                return 1'b0;
            end
            occupied[p[i]] = 1'b1;
        end
        for (int unsigned j = 0; j < npos && found < 4; j++) begin
            if (occupied[j]) begin
                found++;
            end else begin
                subset += binomial(npos - 1 - j, 3 - found);
            end
        end
        rank = subset * ORDERS_PER_SET
             + ((p[0] > p[1]) + (p[0] > p[2]) + (p[0] > p[3])) * 6
             + ((p[1] > p[2]) + (p[1] > p[3])) * 2
             + (p[2] > p[3]);
        return 1'b1;
    endfunction

    function automatic t_out_word rank_state(input t_in_word w);
        logic [4:0]  cf [4];
        logic [4:0]  ef [4];
        int unsigned cp [4];
        int unsigned ep [4];
        int unsigned twist;
        int unsigned flips;
        int unsigned weight;
        int unsigned crank;
        int unsigned erank;
        bit          ok;
        t_out_word   r;
        cf     = '{w.corner_a, w.corner_b, w.corner_c, w.corner_d};
        ef     = '{w.edge_a, w.edge_b, w.edge_c, w.edge_d};
        twist  = 0;
        flips  = 0;
        weight = 1;
        ok     = 1'b1;
        crank  = 0;
        erank  = 0;
        r      = '0;
        for (int i = 0; i < 4; i++) begin
            if (cf[i] > FIELD_TOP || ef[i] > FIELD_TOP) begin
                ok    = 1'b0;
                cf[i] = '0;
                ef[i] = '0;
            end
            cp[i]  = cf[i][2:0];
            twist += cf[i][4:3] * weight;
            weight = weight * 3;
            ep[i]  = ef[i] % 12;
            flips |= (ef[i] / 12) << i;
        end
        if (ok) ok = place_rank(cp, 8, crank);
        if (ok) ok = place_rank(ep, 12, erank);
        if (ok) begin
            r.placement_rank  = 25'(crank * EDGE_SPAN + erank);
            r.twist_flip_rank = 11'(twist * FLIP_WEIGHT + flips);
            r.input_ok        = 1'b1;
        end
        return r;
    endfunction

    // A legal state with random content, or one broken in one of several ways.
    function automatic t_in_word make_state(input bit well_formed);
        logic [4:0] c [4];
        logic [4:0] e [4];
        bit [11:0]  taken;
        int         p;
        int         a;
        int         b;
        taken = '0;
        for (int k = 0; k < 4; k++) begin
            do p = $urandom_range(7); while (taken[p]);
            taken[p] = 1'b1;
            c[k] = 5'($urandom_range(2) * 8 + p);
        end
        taken = '0;
        for (int k = 0; k < 4; k++) begin
            do p = $urandom_range(11); while (taken[p]);
            taken[p] = 1'b1;
            e[k] = 5'($urandom_range(1) * 12 + p);
        end
        a = $urandom_range(3);
        b = (a + 1 + $urandom_range(2)) % 4;
        if (!well_formed) begin
            case ($urandom_range(3))
                0: begin
                    for (int k = 0; k < 4; k++) begin
                        c[k] = 5'($urandom);
                        e[k] = 5'($urandom);
                    end
                end
                1: c[b] = {c[b][4:3], c[a][2:0]};
                2: e[b] = 5'((e[b] >= 12 ? 12 : 0) + e[a] % 12);
                default: begin
                    if ($urandom_range(1)) c[a] = 5'($urandom_range(31, 24));
                    else                   e[a] = 5'($urandom_range(31, 24));
                end
            endcase
        end
        return '{c[0], c[1], c[2], c[3], e[0], e[1], e[2], e[3]};
    endfunction

    task automatic send_state(input t_in_word w);
        t_out_word expected;
        if (send_idle_en) begin
            while ($urandom_range(99) < 31) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        expected = rank_state(w);
        rank_queue.push_back(expected);
        n_sent++;
        if (!expected.input_ok) n_rejected++;
    endtask

    task automatic test_directed_states();
        t_in_word cases [$];
        cases = '{
            t_in_word'{5'd0, 5'd1, 5'd2, 5'd3, 5'd0, 5'd1, 5'd2, 5'd3},
            t_in_word'{5'd23, 5'd22, 5'd21, 5'd20, 5'd23, 5'd22, 5'd21, 5'd20},
            t_in_word'{5'd7, 5'd6, 5'd5, 5'd4, 5'd11, 5'd10, 5'd9, 5'd8},
            t_in_word'{5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11},
            t_in_word'{5'd16, 5'd17, 5'd18, 5'd19, 5'd12, 5'd13, 5'd14, 5'd15},
            t_in_word'{5'd8, 5'd1, 5'd10, 5'd3, 5'd12, 5'd1, 5'd14, 5'd3},
            t_in_word'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            t_in_word'{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
            t_in_word'{5'd24, 5'd1, 5'd2, 5'd3, 5'd0, 5'd1, 5'd2, 5'd3},
            t_in_word'{5'd0, 5'd1, 5'd2, 5'd3, 5'd0, 5'd1, 5'd2, 5'd31},
            t_in_word'{5'd3, 5'd11, 5'd0, 5'd1, 5'd0, 5'd1, 5'd2, 5'd3},
            t_in_word'{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd17, 5'd2, 5'd3},
            t_in_word'{5'd23, 5'd15, 5'd7, 5'd24, 5'd23, 5'd11, 5'd0, 5'd12},
            t_in_word'{5'd2, 5'd13, 5'd20, 5'd0, 5'd6, 5'd19, 5'd23, 5'd4}
        };
        foreach (cases[i]) send_state(cases[i]);
    endtask

    task automatic test_random_states(input int count, input bit with_idle);
        send_idle_en = with_idle;
        recv_idle_en = with_idle;
        repeat (count) send_state(make_state($urandom_range(99) < 85));
    endtask

    // The receiver holds off while legal states keep coming, so the pipeline fills.
    task automatic test_full_pipeline();
        send_idle_en = 1'b0;
        holdoff_req  = 1'b1;
        repeat (40) send_state(make_state(1'b1));
    endtask

    task automatic test_drained_pause();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (rank_queue.size() != 0);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (100) send_state(make_state($urandom_range(99) < 85));
    endtask

    initial begin
        int unsigned hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_idle_en) begin
                i_out_ready <= ($urandom_range(99) >= 31);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (rank_queue.size() == 0) begin
                $error("result word with nothing expected: %h", o_out_word);
                n_errors++;
            end else begin
                want = rank_queue.pop_front();
                if (o_out_word.placement_rank !== want.placement_rank) begin
                    $error("placement_rank: expected %0d, got %0d",
                           want.placement_rank, o_out_word.placement_rank);
                    n_errors++;
                end
                if (o_out_word.twist_flip_rank !== want.twist_flip_rank) begin
                    $error("twist_flip_rank: expected %0d, got %0d",
                           want.twist_flip_rank, o_out_word.twist_flip_rank);
                    n_errors++;
                end
                if (o_out_word.input_ok !== want.input_ok) begin
                    $error("input_ok: expected %0d, got %0d",
                           want.input_ok, o_out_word.input_ok);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("corner_edge_state_rank_index_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        holdoff_req  = 1'b0;
        n_sent       = 0;
        n_rejected   = 0;
        n_results    = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_states();
        test_random_states(600, 1'b1);
        test_random_states(300, 1'b0);
        test_full_pipeline();
        test_random_states(600, 1'b1);
        test_drained_pause();

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (rank_queue.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("Ranked %0d state words (%0d malformed), checked %0d results,",
                 n_sent, n_rejected, n_results);
        $display("including a full-pipeline hold-off and a drained pause.");
        if (n_errors == 0) begin
            $display("corner_edge_state_rank_index_tb: clean");
        end else begin
            $display("corner_edge_state_rank_index_tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ceri_pkg.sv
rtl/ceri_decode.sv
rtl/ceri_terms.sv
rtl/ceri_rank.sv
rtl/ceri_combine.sv
rtl/corner_edge_state_rank_index.sv
verif/corner_edge_state_rank_index_tb.sv
